// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- rtl/chrm_pkg.sv -----
// shared types and constants of the chained hash record map
package chrm_pkg;
    localparam int BUCKETS_DEF = 256;
    localparam int ENTRIES_DEF = 1024;
    localparam int KEY_BYTES_MAX_DEF = 8;
    localparam int WORD_BYTES = 4;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_APPEND = 3'd1;
    localparam logic [2:0] FN_OVERWRITE = 3'd2;
    localparam logic [2:0] FN_GET = 3'd3;
    localparam logic [2:0] FN_DELETE = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_KEY_EXISTS = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    localparam logic CFG_KEY_BYTES = 1'b0;
    localparam logic CFG_BUCKET_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_HEADW,
        S_WALK,
        S_WALKW,
        S_ALLOC,
        S_ALLOCW,
        S_LINK,
        S_DEL,
        S_DELW,
        S_DONE
    } t_state;
endpackage

// ----- rtl/chained_hash_record_map.sv -----
// Chained hash record map: exact-match key/value table with chains per bucket.
// One request is taken at a time. A request first works out the bucket
// modulo (one remainder bit per cycle over the 32-bit key word, then the
// bucket latch) and then reads the bucket head. The chain walk then visits
// each entry in S_WALK and S_WALKW, and leaves S_WALK when it runs off the
// end of the chain. An allocation passes S_ALLOC, S_ALLOCW and S_LINK, an
// unlink S_DEL and S_DELW. The result is produced in S_DONE, which is held
// while a previous result still waits on the output. The memory reads are
// registered. After reset a clearing pass empties the bucket heads and
// refills the free stack; no request is taken meanwhile.
module chained_hash_record_map #(
    parameter int BUCKETS = chrm_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chrm_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES_MAX = chrm_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [8:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[2:0], key[66:3], value[98:67], record_size[114:99], zero fill
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], value_out[33:2], size_out[49:34], zero fill
    output logic [55:0]  m_axis_tdata
);
    localparam int EW = $clog2(ENTRIES + 1);
    localparam int EI = $clog2(ENTRIES);
    localparam int BI = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [EW-1:0] NIL = EW'(ENTRIES);

    chrm_pkg::t_state r_state, n_state;

    logic [3:0] r_kb;
    logic [8:0] r_bc;
    logic [2:0] r_func;
    logic [63:0] r_key;
    logic [31:0] r_val;
    logic [15:0] r_size;
    logic [31:0] r_rem;
    logic [5:0] r_cnt;
    logic [BI-1:0] r_b;
    logic [EW-1:0] r_cur, r_prev, r_head, r_tail, r_nfree, r_new;
    logic [EW-1:0] r_steps;
    logic [EW:0] r_init;
    logic [1:0] r_st;
    logic [31:0] r_vo;
    logic [15:0] r_so;
    logic r_ov;
    logic [55:0] r_out;

    // memories
    logic [EW-1:0] m_head [BUCKETS];
    logic [EW-1:0] m_tail [BUCKETS];
    logic [EW-1:0] m_link [ENTRIES];
    logic [63:0]   m_key  [ENTRIES];
    logic [31:0]   m_data [ENTRIES];
    logic [15:0]   m_len  [ENTRIES];
    logic [EI-1:0] m_free [ENTRIES];
    logic [EW-1:0] q_head, q_tail, q_link;
    logic [63:0] q_key;
    logic [31:0] q_data;
    logic [15:0] q_len;
    logic [EI-1:0] q_free;

    logic [3:0] kb_eff;
    logic [2:0] wb;
    logic [8:0] bc_eff;
    logic [63:0] km;
    logic [31:0] whi;
    logic [31:0] kword;
    logic kbit;
    logic match;
    logic [32:0] trial;

    always_comb begin
        kb_eff = (r_kb == 4'd0) ? 4'd1 :
                 (r_kb > 4'(KEY_BYTES_MAX)) ? 4'(KEY_BYTES_MAX) : r_kb;
        wb = (kb_eff < 4'(chrm_pkg::WORD_BYTES)) ? kb_eff[2:0] : 3'(chrm_pkg::WORD_BYTES);
        bc_eff = (r_bc == 9'd0) ? 9'd1 : (r_bc > 9'(BUCKETS)) ? 9'(BUCKETS) : r_bc;
        for (int i = 0; i < 8; i++) km[i*8 +: 8] = (4'(i) < kb_eff) ? 8'hff : 8'h00;
        for (int i = 0; i < 4; i++) whi[i*8 +: 8] = (3'(i) < wb) ? 8'h00 : 8'hff;
        match = ((q_key & km) == (r_key & km)) && ((q_key[31:0] & whi) == 32'd0);
        kword = r_key[31:0] & ~whi;
        kbit = kword[5'd31 - r_cnt[4:0]];
        trial = {r_rem[31:0], kbit} - 33'(bc_eff);
    end

    wire s_acc = s_axis_tvalid && s_axis_tready;
    wire m_acc = m_axis_tvalid && m_axis_tready;
    wire full = (r_nfree == '0) || (r_nfree > NIL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chrm_pkg::S_INIT: if (r_init >= (EW+1)'(ENTRIES) &&
                                  r_init >= (EW+1)'(BUCKETS)) n_state = chrm_pkg::S_IDLE;
            chrm_pkg::S_IDLE: if (s_acc) n_state = chrm_pkg::S_MOD;
            chrm_pkg::S_MOD: if (r_cnt == 6'd32) n_state = chrm_pkg::S_HEAD;
            chrm_pkg::S_HEAD: n_state = chrm_pkg::S_HEADW;
            chrm_pkg::S_HEADW: begin
                if (r_func == chrm_pkg::FN_APPEND) n_state = chrm_pkg::S_ALLOC;
                else if (r_func > chrm_pkg::FN_DELETE) n_state = chrm_pkg::S_DONE;
                else n_state = chrm_pkg::S_WALK;
            end
            chrm_pkg::S_WALK: begin
                if (r_cur >= NIL || r_steps >= EW'(ENTRIES)) begin
                    n_state = (r_func == chrm_pkg::FN_INSERT ||
                               r_func == chrm_pkg::FN_OVERWRITE) ? chrm_pkg::S_ALLOC
                                                                 : chrm_pkg::S_DONE;
                end else n_state = chrm_pkg::S_WALKW;
            end
            chrm_pkg::S_WALKW: begin
                if (match) begin
                    n_state = (r_func == chrm_pkg::FN_DELETE) ? chrm_pkg::S_DEL
                                                              : chrm_pkg::S_DONE;
                end else n_state = chrm_pkg::S_WALK;
            end
            chrm_pkg::S_ALLOC: n_state = full ? chrm_pkg::S_DONE : chrm_pkg::S_ALLOCW;
            chrm_pkg::S_ALLOCW: n_state = chrm_pkg::S_LINK;
            chrm_pkg::S_LINK: n_state = chrm_pkg::S_DONE;
            chrm_pkg::S_DEL: n_state = chrm_pkg::S_DELW;
            chrm_pkg::S_DELW: n_state = chrm_pkg::S_DONE;
            chrm_pkg::S_DONE: if (!r_ov || m_acc) n_state = chrm_pkg::S_IDLE;
            default: n_state = chrm_pkg::S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == chrm_pkg::S_IDLE);
        m_axis_tvalid = r_ov;
        m_axis_tdata = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chrm_pkg::S_INIT;
            r_kb <= 4'd4;
            r_bc <= 9'd256;
            r_init <= '0;
            r_nfree <= NIL;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == chrm_pkg::CFG_KEY_BYTES) r_kb <= i_cfg_data[3:0];
                else r_bc <= i_cfg_data;
            end
            if (m_acc && r_state != chrm_pkg::S_DONE) r_ov <= 1'b0;
            case (r_state)
                chrm_pkg::S_INIT: r_init <= r_init + 1'b1;
                chrm_pkg::S_IDLE: if (s_acc) begin
                    r_func <= s_axis_tdata[2:0];
                    r_key <= s_axis_tdata[66:3];
                    r_val <= s_axis_tdata[98:67];
                    r_size <= s_axis_tdata[114:99];
                    r_rem <= 32'd0;
                    r_cnt <= 6'd0;
                    r_steps <= '0;
                    r_prev <= NIL;
                    r_st <= chrm_pkg::ST_NOT_FOUND;
                    r_vo <= 32'd0;
                    r_so <= 16'd0;
                end
                chrm_pkg::S_MOD: begin
                    // restoring remainder, one key bit per cycle, msb first
                    if (r_cnt < 6'd32) begin
                        if (!trial[32]) r_rem <= trial[31:0];
                        else r_rem <= {r_rem[30:0], kbit};
                        r_cnt <= r_cnt + 1'b1;
                    end else r_b <= BI'(r_rem);
                end
                chrm_pkg::S_HEADW: begin
                    r_head <= q_head;
                    r_tail <= q_tail;
                    r_cur <= q_head;
                end
                chrm_pkg::S_WALKW: begin
                    r_steps <= r_steps + 1'b1;
                    if (match) begin
                        case (r_func)
                            chrm_pkg::FN_INSERT: r_st <= chrm_pkg::ST_KEY_EXISTS;
                            chrm_pkg::FN_GET: begin
                                r_st <= chrm_pkg::ST_OK;
                                r_vo <= q_data;
                                r_so <= q_len;
                            end
                            default: r_st <= chrm_pkg::ST_OK;
                        endcase
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= q_link;
                    end
                end
                chrm_pkg::S_ALLOC: begin
                    if (full) r_st <= chrm_pkg::ST_TABLE_FULL;
                    else r_nfree <= r_nfree - 1'b1;
                end
                chrm_pkg::S_ALLOCW: begin
                    r_new <= EW'(q_free);
                    r_st <= chrm_pkg::ST_OK;
                end
                chrm_pkg::S_DELW: if (r_nfree < NIL) r_nfree <= r_nfree + 1'b1;
                chrm_pkg::S_DONE: if (!r_ov || m_acc) begin
                    r_ov <= 1'b1;
                    r_out <= {6'd0, r_so, r_vo, r_st};
                end
                default: ;
            endcase
        end
    end

    // memory ports
    logic [EI-1:0] a_e;
    logic [BI-1:0] a_b;
    always_comb begin
        a_e = EI'(r_cur);
        a_b = r_b;
    end

    always_ff @(posedge i_clk) begin
        q_head <= m_head[a_b];
        q_tail <= m_tail[a_b];
        q_link <= m_link[a_e];
        q_key <= m_key[a_e];
        q_data <= m_data[a_e];
        q_len <= m_len[a_e];
        // top of the free stack
        q_free <= m_free[EI'(r_nfree - 1'b1)];
        case (r_state)
            chrm_pkg::S_INIT: begin
                if (r_init < (EW+1)'(BUCKETS)) m_head[BI'(r_init)] <= NIL;
                if (r_init < (EW+1)'(ENTRIES))
                    m_free[EI'(r_init)] <= EI'((EW+1)'(ENTRIES - 1) - r_init);
            end
            chrm_pkg::S_WALKW: if (match && r_func == chrm_pkg::FN_OVERWRITE) begin
                m_data[a_e] <= r_val;
                m_len[a_e] <= r_size;
            end
            chrm_pkg::S_ALLOCW: m_link[q_free] <= NIL;
            chrm_pkg::S_LINK: begin
                m_key[EI'(r_new)] <= r_key & km;
                m_data[EI'(r_new)] <= r_val;
                m_len[EI'(r_new)] <= r_size;
                if (r_head >= NIL) m_head[a_b] <= r_new;
                else if (r_tail < NIL) m_link[EI'(r_tail)] <= r_new;
                m_tail[a_b] <= r_new;
            end
            chrm_pkg::S_DEL: begin
                if (r_prev < NIL) m_link[EI'(r_prev)] <= q_link;
                if (r_head == r_cur) m_head[a_b] <= q_link;
                if (r_tail == r_cur) m_tail[a_b] <= (r_prev < NIL) ? r_prev : '0;
            end
            chrm_pkg::S_DELW: if (r_nfree < NIL) m_free[EI'(r_nfree)] <= EI'(r_cur);
            default: ;
        endcase
    end
endmodule

// ----- rtl/chrm_checker.sv -----
// port-level checks of the chained hash record map
`include "assert_macros.svh"
module chrm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CHK_NEXT(a_one, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CHK_IMPL(a_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0,
        m_axis_tdata[49:2] == 48'd0)
endmodule

bind chained_hash_record_map chrm_checker u_chk (.*);

// ----- tb/sv/tb_chained_hash_record_map.sv -----
// testbench of the chained hash record map: directed and random traffic checked against a table model
module tb_chained_hash_record_map;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT = 256;
    localparam int NENT = 1024;
    localparam int NIL = NENT;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] record_size;
        logic [31:0] value;
        logic [63:0] key;
        logic [2:0]  func;
    } t_req;

    typedef struct packed {
        logic [15:0] size_out;
        logic [31:0] value_out;
        logic [1:0]  status;
    } t_rsp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [8:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;

    chained_hash_record_map u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    int unsigned    keylen_reg, nbkt_reg;
    int unsigned    head[NBKT], tail[NBKT];
    int unsigned    link[NENT], fstack[NENT];
    logic [63:0]    ekey[NENT];
    logic [31:0]    edata[NENT];
    logic [15:0]    elen[NENT];
    int unsigned    nfree;

    t_req req_q[$];
    t_rsp rsp_q[$];
    int   errors = 0, n_sent = 0, n_recv = 0, n_hits = 0, n_full = 0;

    function automatic logic [63:0] mask_bytes(int unsigned n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
    endfunction

    function automatic int unsigned eff_keylen();
        if (keylen_reg == 0) return 1;
        return keylen_reg > 8 ? 8 : keylen_reg;
    endfunction

    function automatic int unsigned bucket_for(logic [63:0] k);
        int unsigned wb, bc;
        wb = eff_keylen() < 4 ? eff_keylen() : 4;
        bc = nbkt_reg == 0 ? 1 : (nbkt_reg > NBKT ? NBKT : nbkt_reg);
        return 32'((k & mask_bytes(wb)) % bc);
    endfunction

    function automatic int unsigned chain_find(int unsigned b, logic [63:0] k,
                                               output int unsigned prev);
        int unsigned wb, cur, p;
        logic [63:0] km, hi;
        wb = eff_keylen() < 4 ? eff_keylen() : 4;
        km = mask_bytes(eff_keylen());
        hi = mask_bytes(4) & ~mask_bytes(wb);
        p = NIL;
        cur = head[b];
        prev = NIL;
        for (int s = 0; s < NENT && cur < NIL; s++) begin
            if ((ekey[cur] & km) == (k & km) && (ekey[cur] & hi) == 0) begin
                prev = p;
                return cur;
            end
            p = cur;
            cur = link[cur];
        end
        return NIL;
    endfunction

    function automatic logic [1:0] chain_append(int unsigned b, t_req r);
        int unsigned e;
        if (nfree == 0) return chrm_pkg::ST_TABLE_FULL;
        nfree--;
        e = fstack[nfree];
        ekey[e] = r.key & mask_bytes(eff_keylen());
        edata[e] = r.value;
        elen[e] = r.record_size;
        link[e] = NIL;
        if (head[b] >= NIL) head[b] = e;
        else link[tail[b]] = e;
        tail[b] = e;
        return chrm_pkg::ST_OK;
    endfunction

    function automatic t_rsp table_apply(t_req r);
        t_rsp o;
        int unsigned b, hit, prev;
        o = '0;
        o.status = chrm_pkg::ST_NOT_FOUND;
        b = bucket_for(r.key);
        case (r.func)
            chrm_pkg::FN_INSERT: begin
                hit = chain_find(b, r.key, prev);
                o.status = hit < NIL ? chrm_pkg::ST_KEY_EXISTS : chain_append(b, r);
            end
            chrm_pkg::FN_APPEND: o.status = chain_append(b, r);
            chrm_pkg::FN_OVERWRITE: begin
                hit = chain_find(b, r.key, prev);
                if (hit < NIL) begin
                    edata[hit] = r.value;
                    elen[hit] = r.record_size;
                    o.status = chrm_pkg::ST_OK;
                end else begin
                    o.status = chain_append(b, r);
                end
            end
            chrm_pkg::FN_GET: begin
                hit = chain_find(b, r.key, prev);
                if (hit < NIL) begin
                    o.status = chrm_pkg::ST_OK;
                    o.value_out = edata[hit];
                    o.size_out = elen[hit];
                end
            end
            chrm_pkg::FN_DELETE: begin
                hit = chain_find(b, r.key, prev);
                if (hit < NIL) begin
                    if (prev < NIL) link[prev] = link[hit];
                    if (head[b] == hit) head[b] = link[hit];
                    if (tail[b] == hit) tail[b] = prev < NIL ? prev : 0;
                    fstack[nfree] = hit;
                    nfree++;
                    o.status = chrm_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && !s_axis_tready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                t_req r;
                r = req_q.pop_front();
                rsp_q.push_back(table_apply(r));
                n_sent <= n_sent + 1;
                s_axis_tdata <= {5'b0, r};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and monitor
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        m_axis_tready <= (stall_phase % 256 < 64) ? 1'b1 : ($urandom_range(0, 2) != 0);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rsp got, exp;
            got = t_rsp'(m_axis_tdata[49:0]);
            n_recv <= n_recv + 1;
            if (rsp_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected word %h", got);
            end else begin
                exp = rsp_q.pop_front();
                if (exp.status == chrm_pkg::ST_OK && exp.value_out != 0) n_hits <= n_hits + 1;
                if (exp.status == chrm_pkg::ST_TABLE_FULL) n_full <= n_full + 1;
                if (got !== exp || m_axis_tdata[55:50] !== '0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: status %0d/%0d value %h/%h size %h/%h (exp/got)",
                                 exp.status, got.status, exp.value_out, got.value_out,
                                 exp.size_out, got.size_out);
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(logic idx, logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == chrm_pkg::CFG_KEY_BYTES) keylen_reg = 32'(val[3:0]);
        else nbkt_reg = 32'(val);
    endtask

    task automatic drain();
        while (req_q.size() > 0 || rsp_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic void push(logic [2:0] f, logic [63:0] k, logic [31:0] v,
                                 logic [15:0] sz);
        t_req r;
        r.func = f; r.key = k; r.value = v; r.record_size = sz;
        req_q.push_back(r);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // random traffic drawn from a small key set so hits, deletes and chains are common
    task automatic random_phase(int n, int nkeys);
        logic [63:0] keys[];
        keys = new[nkeys];
        foreach (keys[i]) keys[i] = rand_key();
        for (int i = 0; i < n; i++) begin
            logic [2:0] f;
            logic [63:0] k;
            f = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            k = ($urandom_range(0, 9) == 0) ? rand_key() : keys[$urandom_range(0, nkeys - 1)];
            push(f, k, $urandom(), 16'($urandom()));
            while (req_q.size() > 8) @(posedge i_clk);
        end
        drain();
    endtask

    initial begin
        keylen_reg = 4;
        nbkt_reg = 256;
        for (int i = 0; i < NBKT; i++) begin head[i] = NIL; tail[i] = 0; end
        for (int i = 0; i < NENT; i++) begin
            fstack[i] = NENT - 1 - i; link[i] = 0; ekey[i] = 0; edata[i] = 0; elen[i] = 0;
        end
        nfree = NENT;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every op, field extremes, duplicates, missing keys, bad codes
        push(chrm_pkg::FN_GET, 64'd5, '1, '1);
        push(chrm_pkg::FN_DELETE, 64'd5, 0, 0);
        push(chrm_pkg::FN_INSERT, 64'd0, 32'd0, 16'd0);
        push(chrm_pkg::FN_INSERT, '1, '1, '1);
        push(chrm_pkg::FN_INSERT, '1, 32'h1234, 16'h55);
        push(chrm_pkg::FN_GET, '1, 0, 0);
        push(chrm_pkg::FN_OVERWRITE, '1, 32'hA5A5A5A5, 16'hFFFF);
        push(chrm_pkg::FN_GET, 64'h00000000FFFFFFFF, 0, 0);
        push(chrm_pkg::FN_APPEND, 64'h100, 32'h1, 16'h1);
        push(chrm_pkg::FN_APPEND, 64'h100, 32'h2, 16'h2);
        push(chrm_pkg::FN_GET, 64'h100, 0, 0);
        push(chrm_pkg::FN_DELETE, 64'h100, 0, 0);
        push(chrm_pkg::FN_GET, 64'h100, 0, 0);
        push(chrm_pkg::FN_OVERWRITE, 64'h77, 32'h77, 16'h7);
        push(3'd5, 64'h77, 0, 0);
        push(3'd7, 64'h77, 0, 0);
        push(chrm_pkg::FN_DELETE, 64'd0, 0, 0);
        push(chrm_pkg::FN_GET, 64'd0, 0, 0);
        drain();

        random_phase(100, 40);
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd8);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd1);
        random_phase(60, 20);
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd1);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd7);
        random_phase(60, 30);
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd0);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd0);
        random_phase(40, 20);
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd15);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd511);
        random_phase(60, 40);

        // fill the pool to exhaustion, then run random traffic on the full pool
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd6);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd256);
        for (int i = 0; i < NENT + 10; i++) begin
            push(chrm_pkg::FN_APPEND, rand_key(), $urandom(), 16'($urandom()));
            while (req_q.size() > 8) @(posedge i_clk);
        end
        drain();
        cfg_write(chrm_pkg::CFG_KEY_BYTES, 9'd3);
        cfg_write(chrm_pkg::CFG_BUCKET_COUNT, 9'd100);
        random_phase(80, 60);

        drain();
        $display("%0d requests, %0d responses, %0d data hits, %0d pool-full answers",
                 n_sent, n_recv, n_hits, n_full);
        $display("key lengths 0..15 and bucket counts 0..511 exercised, pool exhausted once");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/chrm_pkg.sv
rtl/chained_hash_record_map.sv
rtl/chrm_checker.sv
tb/sv/tb_chained_hash_record_map.sv
